>>> rtl/i2ctth_pkg.sv
package i2ctth_pkg;

    localparam int RX_DEPTH_DEFAULT = 32;

    localparam logic [6:0] CONFIG_RD_ADDR = 7'h76;
    localparam logic [6:0] POLL_RD_ADDR   = 7'h77;

    localparam logic [2:0] EV_DONE     = 3'b001;
    localparam logic [2:0] EV_DATA_ERR = 3'b010;
    localparam logic [2:0] EV_BUS_ERR  = 3'b100;

    localparam logic [5:0] RX_LIMIT_RESET = 6'd32;

    localparam logic [3:0] CONF_LEN = 4'd2;
    localparam logic [3:0] POLL_LEN = 4'd8;

    typedef enum logic [2:0] {
        OP_MATCH    = 3'd0,
        OP_DATA     = 3'd1,
        OP_STOP     = 3'd2,
        OP_CONSUMED = 3'd3,
        OP_RELEASE  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        CFG_OWN_ADDR   = 3'd0,
        CFG_OWN_VALID  = 3'd1,
        CFG_CONF_REPLY = 3'd2,
        CFG_POLL_REPLY = 3'd3,
        CFG_RX_LIMIT   = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        REPLY_EMPTY = 2'd0,
        REPLY_CONF  = 2'd1,
        REPLY_POLL  = 2'd2
    } reply_sel_t;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] bus_byte;
        logic       dir_read;
        logic       bus_fault;
        logic       master_nack;
    } item_t;

    typedef struct packed {
        logic       ack;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [4:0] rx_index;
        logic [6:0] rx_address;
        logic       terminate;
        logic       event_valid;
        logic [2:0] event_bits;
        logic       event_dropped;
    } result_t;

    typedef struct packed {
        logic [6:0]  own_address;
        logic        own_address_valid;
        logic [15:0] conf_reply;
        logic [63:0] poll_reply;
        logic [5:0]  rx_limit;
    } cfg_t;

endpackage

>>> rtl/i2ctth_if.sv
interface i2ctth_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] op;
    logic [7:0] bus_byte;
    logic       dir_read;
    logic       bus_fault;
    logic       master_nack;

    modport source (output valid, op, bus_byte, dir_read, bus_fault, master_nack,
                    input ready);
    modport sink (input valid, op, bus_byte, dir_read, bus_fault, master_nack,
                  output ready);
endinterface

interface i2ctth_out_if;
    logic       valid;
    logic       ready;
    logic       ack;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [4:0] rx_index;
    logic [6:0] rx_address;
    logic       terminate;
    logic       event_valid;
    logic [2:0] event_bits;
    logic       event_dropped;

    modport source (output valid, ack, tx_valid, tx_byte, rx_valid, rx_index, rx_address,
                           terminate, event_valid, event_bits, event_dropped,
                    input ready);
    modport sink (input valid, ack, tx_valid, tx_byte, rx_valid, rx_index, rx_address,
                        terminate, event_valid, event_bits, event_dropped,
                  output ready);
endinterface

interface i2ctth_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/i2ctth_cfg_regs.sv
module i2ctth_cfg_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    i2ctth_cfg_if.sink           cfg,
    output i2ctth_pkg::cfg_t     cfg_q
);
    import i2ctth_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_OWN_ADDR:   cfg_next.own_address       = cfg.data[6:0];
                CFG_OWN_VALID:  cfg_next.own_address_valid = cfg.data[0];
                CFG_CONF_REPLY: cfg_next.conf_reply        = cfg.data[15:0];
                CFG_POLL_REPLY: cfg_next.poll_reply        = cfg.data;
                CFG_RX_LIMIT:   cfg_next.rx_limit          = cfg.data[5:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_address       <= '0;
            cfg_reg.own_address_valid <= 1'b0;
            cfg_reg.conf_reply        <= '0;
            cfg_reg.poll_reply        <= '0;
            cfg_reg.rx_limit          <= RX_LIMIT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/i2ctth_in_stage.sv
module i2ctth_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    i2ctth_in_if.sink         req,
    input  logic              advance,
    output logic              item_valid,
    output i2ctth_pkg::item_t item_q
);
    import i2ctth_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    assign req.ready  = !valid_reg || advance;
    assign take       = req.valid && req.ready;
    assign item_valid = valid_reg;
    assign item_q     = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.op          <= req.op;
            item_reg.bus_byte    <= req.bus_byte;
            item_reg.dir_read    <= req.dir_read;
            item_reg.bus_fault   <= req.bus_fault;
            item_reg.master_nack <= req.master_nack;
        end
    end

endmodule

>>> rtl/i2ctth_core.sv
module i2ctth_core #(
    parameter int RX_DEPTH = i2ctth_pkg::RX_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  i2ctth_pkg::item_t   item,
    input  i2ctth_pkg::cfg_t    cfg_q,
    output i2ctth_pkg::result_t res
);
    import i2ctth_pkg::*;

    localparam logic [5:0] RX_CAP = (RX_DEPTH > 63) ? 6'd63 : 6'(RX_DEPTH);

    logic       reading_reg,      reading_next;
    reply_sel_t reply_sel_reg,    reply_sel_next;
    logic [3:0] send_pos_reg,     send_pos_next;
    logic [3:0] reply_len_reg,    reply_len_next;
    logic [5:0] recv_pos_reg,     recv_pos_next;
    logic [6:0] write_target_reg, write_target_next;
    logic [2:0] pending_reg,      pending_next;

    logic [6:0] addr;
    logic [5:0] rx_lim;
    logic [7:0] reply_byte;
    logic [2:0] ev;
    logic       raise;
    logic       err;

    assign addr   = item.bus_byte[7:1];
    assign rx_lim = (cfg_q.rx_limit < RX_CAP) ? cfg_q.rx_limit : RX_CAP;

    always_comb
    begin
        case (reply_sel_reg)
            REPLY_CONF: reply_byte = send_pos_reg[0] ? cfg_q.conf_reply[15:8]
                                                     : cfg_q.conf_reply[7:0];
            REPLY_POLL: reply_byte = cfg_q.poll_reply[{send_pos_reg[2:0], 3'b000} +: 8];
            default:    reply_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        res               = '0;
        reading_next      = reading_reg;
        reply_sel_next    = reply_sel_reg;
        send_pos_next     = send_pos_reg;
        reply_len_next    = reply_len_reg;
        recv_pos_next     = recv_pos_reg;
        write_target_next = write_target_reg;
        pending_next      = pending_reg;
        ev                = '0;
        raise             = 1'b0;
        err               = 1'b0;

        unique case (op_t'(item.op))
            OP_MATCH:
            begin
                ev = item.bus_fault ? EV_BUS_ERR : 3'd0;
                if (item.dir_read)
                begin
                    reading_next  = 1'b1;
                    send_pos_next = 4'd0;
                    if (cfg_q.own_address_valid && addr == cfg_q.own_address)
                    begin
                        reply_sel_next = REPLY_EMPTY;
                        reply_len_next = 4'd0;
                    end
                    else if (addr == CONFIG_RD_ADDR)
                    begin
                        reply_sel_next = REPLY_CONF;
                        reply_len_next = CONF_LEN;
                    end
                    else if (addr == POLL_RD_ADDR)
                    begin
                        reply_sel_next = REPLY_POLL;
                        reply_len_next = POLL_LEN;
                    end
                    else
                    begin
                        reply_sel_next = REPLY_EMPTY;
                        reply_len_next = 4'd0;
                        err            = 1'b1;
                    end
                end
                else
                begin
                    reading_next      = 1'b0;
                    write_target_next = addr;
                    err               = (recv_pos_reg != 6'd0);
                end
                if (err)
                begin
                    ev = ev | EV_DATA_ERR;
                end
                res.ack = !err;
                raise   = (ev != 3'd0);
            end
            OP_DATA:
            begin
                if (reading_reg)
                begin
                    if ((send_pos_reg != 4'd0 && item.master_nack)
                        || send_pos_reg >= reply_len_reg)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        res.tx_valid  = 1'b1;
                        res.tx_byte   = reply_byte;
                        send_pos_next = send_pos_reg + 4'd1;
                    end
                end
                else
                begin
                    if (recv_pos_reg >= rx_lim)
                    begin
                        err = 1'b1;
                    end
                    else
                    begin
                        res.rx_valid   = 1'b1;
                        res.rx_index   = recv_pos_reg[4:0];
                        res.rx_address = write_target_reg;
                        recv_pos_next  = recv_pos_reg + 6'd1;
                    end
                end
                if (err)
                begin
                    res.terminate = 1'b1;
                    ev            = EV_DATA_ERR;
                    raise         = 1'b1;
                end
                else
                begin
                    res.ack = 1'b1;
                end
            end
            OP_STOP:
            begin
                ev    = EV_DONE;
                raise = 1'b1;
            end
            OP_CONSUMED:
            begin
                pending_next = 3'd0;
            end
            OP_RELEASE:
            begin
                recv_pos_next = 6'd0;
            end
            default:
            begin
                res = '0;
            end
        endcase

        if (raise)
        begin
            res.event_bits = ev;
            if (pending_reg != 3'd0)
            begin
                res.event_dropped = 1'b1;
            end
            else
            begin
                res.event_valid = 1'b1;
                pending_next    = ev;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reading_reg      <= 1'b0;
            reply_sel_reg    <= REPLY_EMPTY;
            send_pos_reg     <= '0;
            reply_len_reg    <= '0;
            recv_pos_reg     <= '0;
            write_target_reg <= '0;
            pending_reg      <= '0;
        end
        else if (step)
        begin
            reading_reg      <= reading_next;
            reply_sel_reg    <= reply_sel_next;
            send_pos_reg     <= send_pos_next;
            reply_len_reg    <= reply_len_next;
            recv_pos_reg     <= recv_pos_next;
            write_target_reg <= write_target_next;
            pending_reg      <= pending_next;
        end
    end

`ifndef SYNTHESIS
    a_raised_sets_pending: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.event_valid |=> pending_reg != 3'd0)
        else $error("Raised event did not leave an event pending.");

    a_drop_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.event_dropped |-> pending_reg != 3'd0 && !res.event_valid)
        else $error("Event dropped while none was pending.");

    a_send_advances: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.tx_valid |=> send_pos_reg == 4'($past(send_pos_reg) + 4'd1))
        else $error("Send position did not advance after a reply byte.");

    a_send_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        send_pos_reg <= reply_len_reg)
        else $error("Send position ran past the reply length.");

    a_recv_advances: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.rx_valid |=> recv_pos_reg == 6'($past(recv_pos_reg) + 6'd1))
        else $error("Receive position did not advance after a write word.");
`endif

endmodule

>>> rtl/i2ctth_out_stage.sv
module i2ctth_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  i2ctth_pkg::result_t res,
    output logic                free,
    i2ctth_out_if.source        rsp
);
    import i2ctth_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free = !valid_reg || rsp.ready;

    assign rsp.valid         = valid_reg;
    assign rsp.ack           = res_reg.ack;
    assign rsp.tx_valid      = res_reg.tx_valid;
    assign rsp.tx_byte       = res_reg.tx_byte;
    assign rsp.rx_valid      = res_reg.rx_valid;
    assign rsp.rx_index      = res_reg.rx_index;
    assign rsp.rx_address    = res_reg.rx_address;
    assign rsp.terminate     = res_reg.terminate;
    assign rsp.event_valid   = res_reg.event_valid;
    assign rsp.event_bits    = res_reg.event_bits;
    assign rsp.event_dropped = res_reg.event_dropped;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

>>> rtl/i2ctth_core_top_note.sv
module i2ctth_step_ctrl (
    input  logic item_valid,
    input  logic out_free,
    output logic step
);
    assign step = item_valid && out_free;
endmodule

>>> rtl/i2c_target_transaction_handler_unit.sv
// Channel  Direction  Word
// req      in         bus event: op, bus_byte, dir_read, bus_fault, master_nack
// rsp      out        result: ack, tx and rx fields, terminate, event fields
// cfg      in         register write: index, data
//
// An event passes from acceptance to result through the input register, then the result register.
// One event is accepted per cycle unless rsp stalls; the decode between the registers sets that rate.
// Reset clears the transfer state, the pending event and the registers to their defaults.
// A stalled rsp holds the result; req keeps flowing until both registers are full.
module i2c_target_transaction_handler_unit #(
    parameter int RX_DEPTH = i2ctth_pkg::RX_DEPTH_DEFAULT
) (
    input logic          clk,
    input logic          rst_n,
    i2ctth_in_if.sink    req,
    i2ctth_out_if.source rsp,
    i2ctth_cfg_if.sink   cfg
);
    import i2ctth_pkg::*;

    cfg_t    cfg_q;
    item_t   item_q;
    result_t res;
    logic    item_valid;
    logic    out_free;
    logic    step;

    i2ctth_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    i2ctth_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (out_free),
        .item_valid (item_valid),
        .item_q     (item_q)
    );

    i2ctth_step_ctrl u_step_ctrl (
        .item_valid (item_valid),
        .out_free   (out_free),
        .step       (step)
    );

    i2ctth_core #(
        .RX_DEPTH (RX_DEPTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_q),
        .cfg_q (cfg_q),
        .res   (res)
    );

    i2ctth_out_stage u_out_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (step),
        .res   (res),
        .free  (out_free),
        .rsp   (rsp)
    );

endmodule
